// ----- design/ehp_pkg.sv -----
package ehp_pkg;

    localparam int RECEIVE_WINDOW = 40;
    localparam int SEND_WINDOW    = 37;

    localparam logic [3:0] PH_LAST = 4'd5;

    typedef enum logic [1:0] {
        SLOT_N = 2'd0,
        SLOT_T = 2'd1,
        SLOT_R = 2'd2
    } t_slot;

    typedef enum logic [1:0] {
        V_CONT  = 2'd0,
        V_MATCH = 2'd1,
        V_FAIL  = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [5:0]  header_length;
        logic [3:0]  telegram_digit_count;
        logic [33:0] telegram_number;
        logic [6:0]  hop_limit;
        logic [29:0] router_number;
        logic        matched;
    } t_result;

    // Position of the last byte that may still close the header.
    function automatic logic [5:0] window_last(input logic kind);
        logic [5:0] w;
        if (kind) begin
            w = 6'(SEND_WINDOW - 1);
        end else begin
            w = 6'(RECEIVE_WINDOW - 1);
        end
        return w;
    endfunction

    function automatic logic [3:0] lit_len(input logic kind, input logic [1:0] part);
        logic [3:0] n;
        case ({kind, part})
            3'b000:  n = 4'd8;
            3'b001:  n = 4'd4;
            3'b010:  n = 4'd5;
            3'b100:  n = 4'd7;
            3'b101:  n = 4'd4;
            3'b110:  n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] dig_max(input logic kind, input logic [1:0] part);
        logic [3:0] n;
        case ({kind, part})
            3'b000:  n = 4'd10;
            3'b001:  n = 4'd2;
            3'b010:  n = 4'd9;
            3'b100:  n = 4'd9;
            3'b101:  n = 4'd2;
            3'b110:  n = 4'd10;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic t_slot dig_slot(input logic kind, input logic [1:0] part);
        t_slot s;
        case ({kind, part})
            3'b000:  s = SLOT_N;
            3'b001:  s = SLOT_T;
            3'b010:  s = SLOT_R;
            3'b100:  s = SLOT_R;
            3'b101:  s = SLOT_T;
            3'b110:  s = SLOT_N;
            default: s = SLOT_R;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] lit_char(input logic kind, input logic [1:0] part,
                                            input logic [2:0] idx);
        logic [7:0] c;
        case ({kind, part, idx})
            6'b000_000: c = "R";
            6'b000_001: c = "E";
            6'b000_010: c = "C";
            6'b000_011: c = "E";
            6'b000_100: c = "I";
            6'b000_101: c = "V";
            6'b000_110: c = "E";
            6'b000_111: c = " ";
            6'b001_000: c = "T";
            6'b001_001: c = "T";
            6'b001_010: c = "L";
            6'b001_011: c = " ";
            6'b010_000: c = "F";
            6'b010_001: c = "R";
            6'b010_010: c = "O";
            6'b010_011: c = "M";
            6'b010_100: c = " ";
            6'b100_000: c = "S";
            6'b100_001: c = "E";
            6'b100_010: c = "N";
            6'b100_011: c = "D";
            6'b100_100: c = "T";
            6'b100_101: c = "O";
            6'b100_110: c = " ";
            6'b101_000: c = "T";
            6'b101_001: c = "T";
            6'b101_010: c = "L";
            6'b101_011: c = " ";
            6'b110_000: c = "#";
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/ehp_parser.sv -----
module ehp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_word_valid,
    input  logic [7:0]       i_byte_value,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output ehp_pkg::t_result o_res
);
    import ehp_pkg::*;

    logic        r_header_kind;
    logic [3:0]  r_phase;
    logic [5:0]  r_pos;
    logic [2:0]  r_lit_idx;
    logic [3:0]  r_dcnt;
    logic [29:0] r_router;
    logic [6:0]  r_hop;
    logic [33:0] r_number;
    logic [3:0]  r_tdig;
    logic        r_decided;

    logic [3:0]  n_phase;
    logic [5:0]  n_pos;
    logic [2:0]  n_lit_idx;
    logic [3:0]  n_dcnt;
    logic [29:0] n_router;
    logic [6:0]  n_hop;
    logic [33:0] n_number;
    logic [3:0]  n_tdig;
    logic        n_decided;

    t_verdict    verdict;
    logic [1:0]  part;
    logic [3:0]  len;
    logic [3:0]  dmax;
    t_slot       slot;
    logic [3:0]  lit_next;
    logic [3:0]  digit;
    logic        is_digit;

    assign part     = r_phase[2:1];
    assign len      = lit_len(r_header_kind, part);
    assign dmax     = dig_max(r_header_kind, part);
    assign slot     = dig_slot(r_header_kind, part);
    assign lit_next = {1'b0, r_lit_idx} + 4'd1;
    assign is_digit = (i_byte_value >= "0") && (i_byte_value <= "9");
    assign digit    = 4'(i_byte_value - "0");

    always_comb begin
        verdict   = V_CONT;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_lit_idx = r_lit_idx;
        n_dcnt    = r_dcnt;
        n_router  = r_router;
        n_hop     = r_hop;
        n_number  = r_number;
        n_tdig    = r_tdig;
        n_decided = r_decided;

        if (i_byte_value == 8'h00 || r_phase > PH_LAST) begin
            verdict = V_FAIL;
        end else if (!r_phase[0]) begin
            if ({1'b0, r_lit_idx} >= len
                || i_byte_value != lit_char(r_header_kind, part, r_lit_idx)) begin
                verdict = V_FAIL;
            end else if (lit_next >= len) begin
                n_lit_idx = 3'd0;
                n_dcnt    = 4'd0;
                n_phase   = r_phase + 4'd1;
            end else begin
                n_lit_idx = lit_next[2:0];
            end
        end else if (is_digit) begin
            if (r_dcnt >= dmax) begin
                verdict = V_FAIL;
            end else begin
                n_dcnt = r_dcnt + 4'd1;
                case (slot)
                    SLOT_N: n_number = {r_number[30:0], 3'b0} + {r_number[32:0], 1'b0}
                                       + {30'd0, digit};
                    SLOT_T: n_hop = {r_hop[3:0], 3'b0} + {r_hop[5:0], 1'b0}
                                    + {3'd0, digit};
                    default: n_router = {r_router[26:0], 3'b0} + {r_router[28:0], 1'b0}
                                        + {26'd0, digit};
                endcase
            end
        end else if (i_byte_value == " " && r_dcnt != 4'd0) begin
            if (slot == SLOT_N) begin
                n_tdig = r_dcnt;
            end
            n_dcnt    = 4'd0;
            n_lit_idx = 3'd0;
            if (r_phase == PH_LAST) begin
                verdict = V_MATCH;
            end else begin
                n_phase = r_phase + 4'd1;
            end
        end else begin
            verdict = V_FAIL;
        end

        // The header must close inside the window and before the buffer ends.
        if (verdict == V_CONT && (r_pos >= window_last(r_header_kind) || i_last_byte)) begin
            verdict = V_FAIL;
        end

        if (verdict == V_CONT) begin
            n_pos = r_pos + 6'd1;
        end else begin
            n_decided = 1'b1;
        end
    end

    always_comb begin
        o_res_valid = i_word_valid && !r_decided && (verdict != V_CONT);
        o_res       = '0;
        if (verdict == V_MATCH) begin
            o_res.matched              = 1'b1;
            o_res.router_number        = r_router;
            o_res.hop_limit            = r_hop;
            o_res.telegram_number      = r_number;
            o_res.telegram_digit_count = n_tdig;
            o_res.header_length        = r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_kind <= 1'b0;
        end else if (i_cfg_we) begin
            r_header_kind <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_word_valid && i_last_byte)) begin
            r_phase   <= 4'd0;
            r_pos     <= 6'd0;
            r_lit_idx <= 3'd0;
            r_dcnt    <= 4'd0;
            r_router  <= '0;
            r_hop     <= '0;
            r_number  <= '0;
            r_tdig    <= 4'd0;
            r_decided <= 1'b0;
        end else if (i_word_valid && !r_decided) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_lit_idx <= n_lit_idx;
            r_dcnt    <= n_dcnt;
            r_router  <= n_router;
            r_hop     <= n_hop;
            r_number  <= n_number;
            r_tdig    <= n_tdig;
            r_decided <= n_decided;
        end
    end

endmodule

// ----- design/ehp_out_reg.sv -----
module ehp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  ehp_pkg::t_result i_res,
    input  logic             i_m_ready,
    output logic             o_in_ready,
    output logic             o_m_valid,
    output ehp_pkg::t_result o_m_res
);
    import ehp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new word when empty or when its word leaves now.
    assign o_in_ready = !r_valid || i_m_ready;
    assign o_m_valid  = r_valid;
    assign o_m_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- design/express_header_parser_unit.sv -----
// Routing header matcher for messages streamed one byte per word.
// Slave channel: tdata[7:0] carries one message byte, tlast marks the final
// byte of the message buffer. A zero byte ends the message text.
// Master channel: one result word per message, given once the header has
// matched or failed; bytes after that decision up to tlast give nothing.
// Configuration: i_cfg_we writes i_cfg_wdata into the header form register
// (0 receive form, 1 send form); write it only between messages.
// Throughput: one byte per cycle while tready is high. The parser state updates in the
// same cycle a byte is accepted, so the next byte can follow at once.
// The result word is registered and valid in the cycle after the deciding byte.
// A single output register holds the result; while it is full and the
// receiver stalls, tready drops and the byte stream waits.
// Reset (synchronous, active low) clears the parser to the start of a
// message, empties the output register and selects the receive form.
// After a tlast byte the parser returns to the start of a message.
module express_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,      // header_kind
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] matched, [30:1] router_number, [37:31] hop_limit,
    // [71:38] telegram_number, [75:72] telegram_digit_count,
    // [81:76] header_length, [87:82] zero
    output logic [87:0] o_m_axis_tdata
);
    import ehp_pkg::*;

    logic    word_valid;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign word_valid = i_s_axis_tvalid && o_s_axis_tready;

    ehp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_word_valid (word_valid),
        .i_byte_value (i_s_axis_tdata),
        .i_last_byte  (i_s_axis_tlast),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    ehp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_m_ready   (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_res     (out_res)
    );

    assign o_m_axis_tdata = {6'd0, out_res};

endmodule

// ----- bench/express_header_parser_unit_test.sv -----
`timescale 1ns / 1ps

module express_header_parser_unit_test;
    import ehp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTES_PER_PHASE = 500;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_msg_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [87:0] m_data;

    express_header_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #5 i_clk = ~i_clk;

    t_msg_byte   pending_bytes[$];
    logic [7:0]  msg_bytes[$];
    t_result     expected_headers[$];
    int          mismatches = 0;

    // Shadow of the header form register and of the parser state.
    logic        hdr_kind = 1'b0;
    int          hp_phase = 0;
    int          hp_pos = 0;
    int          hp_lit = 0;
    int          hp_digits = 0;
    logic [29:0] hp_router = '0;
    logic [6:0]  hp_hop = '0;
    logic [33:0] hp_telegram = '0;
    logic [3:0]  hp_tdig = '0;
    logic        hp_decided = 1'b0;

    function automatic string literal_text(logic kind, int part);
        string s;
        if (!kind) begin
            if (part == 0) s = "RECEIVE ";
            else if (part == 1) s = "TTL ";
            else s = "FROM ";
        end else begin
            if (part == 0) s = "SENDTO ";
            else if (part == 1) s = "TTL ";
            else s = "#";
        end
        return s;
    endfunction

    // The telegram number is the first number of the receive form and the
    // last one of the send form; the router number takes the other end.
    function automatic t_slot number_slot(logic kind, int part);
        t_slot s;
        if (part == 1) s = SLOT_T;
        else if ((part == 0) == !kind) s = SLOT_N;
        else s = SLOT_R;
        return s;
    endfunction

    function automatic int digit_limit(logic kind, int part);
        int n;
        case (number_slot(kind, part))
            SLOT_N:  n = 10;
            SLOT_T:  n = 2;
            default: n = 9;
        endcase
        return n;
    endfunction

    function automatic void clear_message();
        hp_phase = 0;
        hp_pos = 0;
        hp_lit = 0;
        hp_digits = 0;
        hp_router = '0;
        hp_hop = '0;
        hp_telegram = '0;
        hp_tdig = '0;
        hp_decided = 1'b0;
    endfunction

    function automatic t_verdict scan_byte(logic [7:0] b, logic kind);
        string       lit;
        int          part;
        t_slot       slot;
        logic [63:0] d;
        if (b == 8'h00 || hp_phase > PH_LAST) return V_FAIL;
        part = hp_phase / 2;
        if (hp_phase % 2 == 0) begin
            lit = literal_text(kind, part);
            if (hp_lit >= lit.len() || b != lit[hp_lit]) return V_FAIL;
            hp_lit++;
            if (hp_lit >= lit.len()) begin
                hp_lit = 0;
                hp_digits = 0;
                hp_phase++;
            end
            return V_CONT;
        end
        slot = number_slot(kind, part);
        if (b >= "0" && b <= "9") begin
            if (hp_digits >= digit_limit(kind, part)) return V_FAIL;
            hp_digits++;
            d = 64'(b - "0");
            case (slot)
                SLOT_N:  hp_telegram = 34'(hp_telegram * 10 + d);
                SLOT_T:  hp_hop = 7'(hp_hop * 10 + d);
                default: hp_router = 30'(hp_router * 10 + d);
            endcase
            return V_CONT;
        end
        if (b == " " && hp_digits != 0) begin
            if (slot == SLOT_N) hp_tdig = 4'(hp_digits);
            hp_digits = 0;
            hp_lit = 0;
            if (hp_phase == PH_LAST) return V_MATCH;
            hp_phase++;
            return V_CONT;
        end
        return V_FAIL;
    endfunction

    task automatic hdr_predict_byte(logic [7:0] b, logic is_last);
        t_verdict v;
        t_result  r;
        int       window;
        window = hdr_kind ? SEND_WINDOW : RECEIVE_WINDOW;
        if (!hp_decided) begin
            v = scan_byte(b, hdr_kind);
            if (v == V_CONT && hp_pos + 1 >= window) v = V_FAIL;
            if (v == V_CONT && is_last) v = V_FAIL;
            r = '0;
            if (v == V_MATCH) begin
                r.matched = 1'b1;
                r.router_number = hp_router;
                r.hop_limit = hp_hop;
                r.telegram_number = hp_telegram;
                r.telegram_digit_count = hp_tdig;
                r.header_length = 6'(hp_pos + 1);
            end
            if (v != V_CONT) begin
                expected_headers.push_back(r);
                hp_decided = 1'b1;
            end else begin
                hp_pos++;
            end
        end
        if (is_last) clear_message();
    endtask

    // Byte source: the gap before each byte is drawn when the previous one
    // is loaded, with occasional runs that send back to back.
    int   send_gap = 0;
    logic send_steady = 1'b0;

    always @(posedge i_clk) begin
        t_msg_byte w;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) hdr_predict_byte(s_data, s_last);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    w = pending_bytes.pop_front();
                    s_data <= w.value;
                    s_last <= w.is_last;
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 99) == 0) send_steady <= !send_steady;
                    send_gap <= send_steady ? 0 : $urandom_range(0, 5);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    int   recv_stall = 0;
    logic recv_steady = 1'b0;

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int      drawn;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else if (m_valid && m_ready) begin
            got = t_result'(m_data[81:0]);
            if (expected_headers.size() == 0) begin
                $display("%0t: result word with none expected, expected none actual %h",
                         $time, got);
                mismatches++;
            end else begin
                want = expected_headers.pop_front();
                report_field("matched", 64'(want.matched), 64'(got.matched));
                report_field("router_number", 64'(want.router_number),
                             64'(got.router_number));
                report_field("hop_limit", 64'(want.hop_limit), 64'(got.hop_limit));
                report_field("telegram_number", 64'(want.telegram_number),
                             64'(got.telegram_number));
                report_field("telegram_digit_count", 64'(want.telegram_digit_count),
                             64'(got.telegram_digit_count));
                report_field("header_length", 64'(want.header_length),
                             64'(got.header_length));
            end
            if ($urandom_range(0, 29) == 0) recv_steady <= !recv_steady;
            drawn = recv_steady ? 0 : $urandom_range(0, 5);
            if (drawn != 0) m_ready <= 1'b0;
            recv_stall <= drawn;
        end else if (!m_ready) begin
            if (recv_stall <= 1) m_ready <= 1'b1;
            if (recv_stall > 0) recv_stall <= recv_stall - 1;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("express_header_parser_unit_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    // Digits are mostly random, sometimes all nines or all zeros.
    task automatic push_digits(int count);
        int mode;
        mode = $urandom_range(0, 7);
        for (int i = 0; i < count; i++) begin
            if (mode == 0) msg_bytes.push_back("9");
            else if (mode == 1) msg_bytes.push_back("0");
            else msg_bytes.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    task automatic queue_message();
        t_msg_byte w;
        for (int i = 0; i < msg_bytes.size(); i++) begin
            w.value = msg_bytes[i];
            w.is_last = (i == msg_bytes.size() - 1);
            pending_bytes.push_back(w);
        end
        msg_bytes.delete();
    endtask

    task automatic build_header(logic form, int nd, int td, int rd);
        if (!form) begin
            push_text("RECEIVE ");
            push_digits(nd);
            push_text(" TTL ");
            push_digits(td);
            push_text(" FROM ");
            push_digits(rd);
            push_text(" ");
        end else begin
            push_text("SENDTO ");
            push_digits(rd);
            push_text(" TTL ");
            push_digits(td);
            push_text(" #");
            push_digits(nd);
            push_text(" ");
        end
    endtask

    task automatic add_random_message(logic form, inout int counted);
        int nd, td, rd, pick, at, nbody;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            // Noise: a short run of arbitrary bytes.
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
        end else begin
            nd = ($urandom_range(0, 4) == 0) ? 10 : $urandom_range(1, 10);
            td = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(1, 2);
            rd = ($urandom_range(0, 4) == 0) ? 9 : $urandom_range(1, 9);
            if (pick < 8) begin
                case ($urandom_range(0, 2))
                    0:       nd = 11;
                    1:       td = 3;
                    default: rd = 10;
                endcase
            end else if (pick < 12) begin
                case ($urandom_range(0, 2))
                    0:       nd = 0;
                    1:       td = 0;
                    default: rd = 0;
                endcase
            end else if (pick < 17) begin
                nd = 10;
                td = 2;
                rd = 9;
            end else if (pick < 25) begin
                form = !form;
            end
            build_header(form, nd, td, rd);
            at = $urandom_range(0, msg_bytes.size() - 1);
            if (pick >= 25 && pick < 35) msg_bytes[at] = 8'($urandom);
            if (pick >= 35 && pick < 40) msg_bytes[at] = 8'h00;
            if (pick >= 40 && pick < 48) begin
                // The buffer ends somewhere inside the header.
                while (msg_bytes.size() > at + 1) void'(msg_bytes.pop_back());
            end
        end
        counted += msg_bytes.size();
        nbody = (pick >= 40 && pick < 48) ? 0 : $urandom_range(0, 5);
        for (int i = 0; i < nbody; i++) begin
            b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
            msg_bytes.push_back(b);
        end
        queue_message();
    endtask

    // Settles only once every byte is taken and every result has arrived,
    // then leaves room for a byte that is still being parsed.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_headers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic phase_kind[4];
        int   counted;
        phase_kind = '{1'b0, 1'b1, 1'b0, 1'b1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_wdata <= phase_kind[ph];
            hdr_kind = phase_kind[ph];
            @(posedge i_clk);
            cfg_we <= 1'b0;
            if (ph == 0) begin
                push_text("RECEIVE 9999999999 TTL 99 FROM 1 x");
                queue_message();
                push_text("RECEIVE 0 TTL 0 FROM 999999999 ");
                queue_message();
                // The longest receive header overruns its window.
                push_text("RECEIVE 1234567890 TTL 12 FROM 123456789 ");
                queue_message();
                msg_bytes.push_back(8'h00);
                queue_message();
                msg_bytes.push_back(8'hFF);
                queue_message();
                push_text("REC");
                queue_message();
                push_text("RECEIVE 12345678901");
                queue_message();
                push_text("RECEIVE  ");
                queue_message();
            end else if (ph == 1) begin
                push_text("SENDTO 999999999 TTL 99 #9999999999 ");
                msg_bytes.push_back(8'h00);
                msg_bytes.push_back(8'hAA);
                queue_message();
                push_text("SENDTO 5 TTL 7 #");
                msg_bytes.push_back(8'h00);
                msg_bytes.push_back(8'h55);
                queue_message();
                push_text("SENDTO 1 TTL 2 #3 ");
                queue_message();
            end
            counted = 0;
            while (counted < BYTES_PER_PHASE) add_random_message(phase_kind[ph], counted);
        end
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_headers.size() != 0) begin
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, expected_headers.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("express_header_parser_unit_test: clean");
        end else begin
            $display("express_header_parser_unit_test: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/ehp_pkg.sv
design/ehp_parser.sv
design/ehp_out_reg.sv
design/express_header_parser_unit.sv
bench/express_header_parser_unit_test.sv
